/* hdl/lsi_pkg.sv */
// Shared types and constants for the Lagrange stencil interpolator.
package lsi_pkg;

  localparam int unsigned FracBits = 16;
  localparam logic signed [63:0] WLimit = 64'sd2147483647;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusNoFit    = 2'd1;
  localparam logic [1:0] StatusEqualPos = 2'd2;
  localparam logic [1:0] StatusSat      = 2'd3;

  localparam logic OpStore = 1'b0;
  localparam logic OpEval  = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_item;  // capture eval item fields
    logic rd_req;     // issue store read for stencil point
    logic rd_cap;     // capture read data into stencil register
    logic cmp_step;   // compare one pair of positions
    logic w_init;     // start a new weight (w = 1.0)
    logic div_start;  // start a ratio divide
    logic take_div;   // latch clamped ratio from divider
    logic mul_wr;     // form w * r
    logic rescale;    // w = rounded, clamped (w * r) / 1.0
    logic mul_wc;     // form w * coeff
    logic acc_term;   // add rounded (w * coeff) / 1.0 to sum
    logic finish;     // build result word
  } lsi_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic div_done;
    logic eq_found;
  } lsi_stat_t;

endpackage

/* hdl/lsi_divider.sv */
// Sequential signed divider, rounding half away from zero, one quotient bit per cycle.
module lsi_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] num_i,
  input  logic signed [63:0] den_i,
  output logic               done_o,
  output logic signed [63:0] quot_o
);

  localparam int unsigned Bits = 65;

  logic [Bits-1:0] rem_q, rem_d;
  logic [Bits-1:0] dvd_q, dvd_d;
  logic [Bits-1:0] dvs_q, dvs_d;
  logic [6:0]      cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            neg_q, neg_d;
  logic            done_q, done_d;

  logic [63:0]     an, ad;
  logic [Bits-1:0] trial;
  logic [Bits-1:0] shifted;

  assign an = num_i[63] ? 64'(-num_i) : 64'(num_i);
  assign ad = den_i[63] ? 64'(-den_i) : 64'(den_i);
  assign shifted = {rem_q[Bits-2:0], dvd_q[Bits-1]};
  assign trial = shifted - dvs_q;

  // Restoring division of (2|n|+|d|) by 2|d|
  always_comb begin
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      dvd_d  = {an, 1'b0} + {1'b0, ad};
      dvs_d  = {ad, 1'b0};
      cnt_d  = 7'(Bits);
      busy_d = 1'b1;
      neg_d  = num_i[63] ^ den_i[63];
    end else if (busy_q) begin
      dvd_d = {dvd_q[Bits-2:0], ~trial[Bits-1]};
      rem_d = trial[Bits-1] ? shifted : trial;
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed(dvd_q[63:0]) : $signed(dvd_q[63:0]);

endmodule

/* hdl/lsi_datapath.sv */
// Datapath: point store, stencil registers, weight arithmetic and accumulator.
module lsi_datapath #(
  parameter int unsigned StencilHalf = 2,
  parameter int unsigned MaxLevels = 8,
  parameter int unsigned PointsPerLevel = 256
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lsi_pkg::lsi_cmd_t       cmd_i,
  output lsi_pkg::lsi_stat_t      stat_o,
  input  logic [$clog2(2*StencilHalf)-1:0] l_i,
  input  logic [$clog2(2*StencilHalf)-1:0] k_i,
  input  logic                    st_we_i,
  input  logic [2:0]              st_level_i,
  input  logic [7:0]              st_index_i,
  input  logic signed [31:0]      st_pos_i,
  input  logic signed [31:0]      st_coef_i,
  input  logic [2:0]              ev_level_i,
  input  logic signed [31:0]      ev_pos_i,
  input  logic [7:0]              ev_center_i,
  input  logic [8:0]              ev_count_i,
  output logic                    nofit_o,
  output logic signed [31:0]      value_o,
  output logic [1:0]              status_o
);

  localparam int unsigned Span = 2 * StencilHalf;
  localparam int unsigned LvW = (MaxLevels > 1) ? $clog2(MaxLevels) : 1;
  localparam int unsigned IxW = $clog2(PointsPerLevel);
  localparam int unsigned AW = LvW + IxW;
  localparam int unsigned Depth = MaxLevels * PointsPerLevel;

  // Point store: position in upper word, coefficient in lower word
  logic [63:0] mem [Depth];
  logic [63:0] rd_q;

  logic signed [31:0] pos_q [Span];
  logic signed [31:0] coef_q [Span];
  logic signed [31:0] x_q;
  logic [AW-1:0]      base_q;
  logic [9:0]         left_q;
  logic signed [31:0] w_q, r_q;
  logic signed [63:0] prod_q, sum_q;
  logic               sat_q, eq_q;
  logic signed [31:0] value_q;
  logic [1:0]         status_q;

  logic               div_done;
  logic signed [63:0] div_q;
  logic signed [63:0] num, den;
  logic signed [63:0] r_clamp, w_clamp, rnd;
  logic               r_over, w_over;

  // Write a point; out-of-range stores are dropped
  always_ff @(posedge clk_i) begin
    if (st_we_i && 32'(st_level_i) < MaxLevels && 32'(st_index_i) < PointsPerLevel) begin
      mem[AW'(32'(st_level_i) * PointsPerLevel + 32'(st_index_i))] <= {st_pos_i, st_coef_i};
    end
    if (cmd_i.rd_req) begin
      rd_q <= mem[base_q + AW'(left_q) + AW'(l_i)];
    end
  end

  // Fit check and stencil left edge
  logic signed [10:0] left_c;
  always_comb begin
    left_c = $signed({3'b0, ev_center_i}) - 11'(StencilHalf) + 11'sd1;
    if (left_c < 0) left_c = '0;
    if (left_c > $signed({2'b0, ev_count_i}) - 11'(Span))
      left_c = $signed({2'b0, ev_count_i}) - 11'(Span);
  end
  assign nofit_o = (32'(ev_level_i) >= MaxLevels) || (32'(ev_count_i) < Span)
                || (32'(ev_count_i) > PointsPerLevel);

  // Ratio operands: (x - pos[k]) * 1.0 over pos[l] - pos[k]
  assign num = (64'(x_q) - 64'(pos_q[k_i])) <<< lsi_pkg::FracBits;
  assign den = 64'(pos_q[l_i]) - 64'(pos_q[k_i]);

  lsi_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (num),
    .den_i  (den),
    .done_o (div_done),
    .quot_o (div_q)
  );

  // Divide the product by 1.0, halves away from zero
  assign rnd = (prod_q + (prod_q[63] ? 64'sd32767 : 64'sd32768)) >>> lsi_pkg::FracBits;

  // Clamp ratio and weight to the symmetric 32-bit range
  always_comb begin
    r_over = 1'b0;
    r_clamp = div_q;
    if (div_q > lsi_pkg::WLimit) begin
      r_clamp = lsi_pkg::WLimit; r_over = 1'b1;
    end else if (div_q < -lsi_pkg::WLimit) begin
      r_clamp = -lsi_pkg::WLimit; r_over = 1'b1;
    end
    w_over = 1'b0;
    w_clamp = rnd;
    if (rnd > lsi_pkg::WLimit) begin
      w_clamp = lsi_pkg::WLimit; w_over = 1'b1;
    end else if (rnd < -lsi_pkg::WLimit) begin
      w_clamp = -lsi_pkg::WLimit; w_over = 1'b1;
    end
  end

  // Sequence the arithmetic registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      x_q    <= ev_pos_i;
      base_q <= AW'(32'(ev_level_i) * PointsPerLevel);
      left_q <= 10'(left_c);
      sum_q  <= '0;
      sat_q  <= 1'b0;
      eq_q   <= 1'b0;
    end
    if (cmd_i.rd_cap) begin
      pos_q[l_i]  <= rd_q[63:32];
      coef_q[l_i] <= rd_q[31:0];
    end
    if (cmd_i.cmp_step && pos_q[l_i] == pos_q[k_i]) eq_q <= 1'b1;
    if (cmd_i.w_init) w_q <= 32'sd65536;
    if (cmd_i.take_div) begin
      r_q <= r_clamp[31:0];
      if (r_over) sat_q <= 1'b1;
    end
    if (cmd_i.mul_wr) prod_q <= w_q * r_q;
    if (cmd_i.mul_wc) prod_q <= w_q * coef_q[l_i];
    if (cmd_i.rescale) begin
      w_q <= w_clamp[31:0];
      if (w_over) sat_q <= 1'b1;
    end
    if (cmd_i.acc_term) sum_q <= sum_q + rnd;
    if (cmd_i.finish) begin
      if (eq_q) begin
        value_q <= '0; status_q <= lsi_pkg::StatusEqualPos;
      end else if (sum_q > 64'sd2147483647) begin
        value_q <= 32'sh7fffffff; status_q <= lsi_pkg::StatusSat;
      end else if (sum_q < -64'sd2147483648) begin
        value_q <= 32'sh80000000; status_q <= lsi_pkg::StatusSat;
      end else begin
        value_q  <= sum_q[31:0];
        status_q <= sat_q ? lsi_pkg::StatusSat : lsi_pkg::StatusOk;
      end
    end
  end

  assign stat_o.div_done = div_done;
  assign stat_o.eq_found = eq_q;
  assign value_o  = value_q;
  assign status_o = status_q;

endmodule

/* hdl/lsi_ctrl.sv */
// Controller: sequences stencil reads, equality checks and weight arithmetic.
module lsi_ctrl #(
  parameter int unsigned StencilHalf = 2
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    op_i,
  input  logic                    nofit_i,
  input  lsi_pkg::lsi_stat_t      stat_i,
  output lsi_pkg::lsi_cmd_t       cmd_o,
  output logic [$clog2(2*StencilHalf)-1:0] l_o,
  output logic [$clog2(2*StencilHalf)-1:0] k_o,
  output logic                    st_we_o,
  output logic                    res_nofit_o,
  output logic                    out_load_o
);

  localparam int unsigned Span = 2 * StencilHalf;
  localparam int unsigned SW = $clog2(Span);
  localparam logic [SW-1:0] Last = SW'(Span - 1);

  typedef enum logic [3:0] {
    SIdle, SRdReq, SRdCap, SCmp, SWInit, SSkip, SRatio, SWaitR,
    SMulWr, SRescale, SMulWc, SAccum, SFinish, SOut
  } state_e;

  state_e        state_q;
  logic [SW-1:0] l_q, k_q;
  logic          nofit_q;

  assign in_ready_o  = (state_q == SIdle);
  assign st_we_o     = in_valid_i && in_ready_o && (op_i == lsi_pkg::OpStore);
  assign l_o         = l_q;
  assign k_o         = k_q;
  assign res_nofit_o = nofit_q;
  assign out_load_o  = (state_q == SOut);

  // Decode commands from state
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      SIdle:    cmd_o.load_item = in_valid_i && (op_i == lsi_pkg::OpEval);
      SRdReq:   cmd_o.rd_req = 1'b1;
      SRdCap:   cmd_o.rd_cap = 1'b1;
      SCmp:     cmd_o.cmp_step = 1'b1;
      SWInit:   cmd_o.w_init = 1'b1;
      SSkip:    ;
      SRatio:   cmd_o.div_start = 1'b1;
      SWaitR:   cmd_o.take_div = stat_i.div_done;
      SMulWr:   cmd_o.mul_wr = 1'b1;
      SRescale: cmd_o.rescale = 1'b1;
      SMulWc:   cmd_o.mul_wc = 1'b1;
      SAccum:   cmd_o.acc_term = 1'b1;
      SFinish:  cmd_o.finish = 1'b1;
      SOut:     ;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      l_q <= '0; k_q <= '0;
      nofit_q <= 1'b0;
    end else begin
      unique case (state_q)
        SIdle: if (in_valid_i && op_i == lsi_pkg::OpEval) begin
          l_q <= '0; k_q <= '0;
          nofit_q <= nofit_i;
          state_q <= nofit_i ? SOut : SRdReq;
        end
        SRdReq: state_q <= SRdCap;
        SRdCap: if (l_q == Last) begin
          l_q <= '0; k_q <= SW'(1); state_q <= SCmp;
        end else begin
          l_q <= l_q + SW'(1); state_q <= SRdReq;
        end
        SCmp: if (k_q == Last) begin
          if (l_q == SW'(Span - 2)) begin
            l_q <= '0; k_q <= '0; state_q <= SWInit;
          end else begin
            l_q <= l_q + SW'(1); k_q <= l_q + SW'(2);
          end
        end else k_q <= k_q + SW'(1);
        SWInit: state_q <= stat_i.eq_found ? SFinish : SSkip;
        // Skip k equal to l; leave for the term once k has run out
        SSkip: if (k_q == l_q) begin
          if (k_q == Last) state_q <= SMulWc;
          else k_q <= k_q + SW'(1);
        end else state_q <= SRatio;
        SRatio: state_q <= SWaitR;
        SWaitR: if (stat_i.div_done) state_q <= SMulWr;
        SMulWr: state_q <= SRescale;
        SRescale: if (k_q == Last) state_q <= SMulWc;
        else begin
          k_q <= k_q + SW'(1); state_q <= SSkip;
        end
        SMulWc: state_q <= SAccum;
        SAccum: begin
          k_q <= '0;
          if (l_q == Last) state_q <= SFinish;
          else begin l_q <= l_q + SW'(1); state_q <= SWInit; end
        end
        SFinish: state_q <= SOut;
        SOut: state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
    end
  end

endmodule

/* hdl/lagrange_stencil_interpolator.sv */
// Lagrange stencil interpolator top level: controller, datapath and output register.
// One item is handled at a time and a new word is taken only while no result word
// waits. A store is written when it is accepted. An evaluation reads the
// 2*STENCIL_HALF stencil points one at a time, checks position pairs (one pair a
// cycle), then builds each weight from 2*STENCIL_HALF-1 ratios; every ratio is a
// 65-step division on the one shared divider followed by a multiply and a rescale,
// and each term is a multiply and an accumulate. For STENCIL_HALF = 2 an evaluation
// runs twelve ratio divides. An evaluation whose stencil does not fit goes straight
// to the output word, one with equal positions right after the pair checks. Points
// read from the store must have been written first.
module lagrange_stencil_interpolator #(
  parameter int unsigned STENCIL_HALF = 2,
  parameter int unsigned MAX_LEVELS = 8,
  parameter int unsigned POINTS_PER_LEVEL = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic [2:0]         level_i,
  input  logic [7:0]         point_index_i,
  input  logic signed [31:0] point_position_i,
  input  logic signed [31:0] point_coefficient_i,
  input  logic signed [31:0] eval_position_i,
  input  logic [7:0]         center_index_i,
  input  logic [8:0]         points_at_level_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] value_o,
  output logic [1:0]         status_o
);

  localparam int unsigned SW = $clog2(2 * STENCIL_HALF);

  lsi_pkg::lsi_cmd_t  cmd;
  lsi_pkg::lsi_stat_t stat;
  logic [SW-1:0]      l_idx, k_idx;
  logic               st_we, nofit, res_nofit, out_load, ctrl_ready;
  logic signed [31:0] dp_value;
  logic [1:0]         dp_status;

  logic               out_valid_q;
  logic signed [31:0] value_q;
  logic [1:0]         status_q;

  // Hold the controller while a result word still waits
  assign in_ready_o = ctrl_ready && !out_valid_q;

  lsi_ctrl #(.StencilHalf(STENCIL_HALF)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i && !out_valid_q),
    .in_ready_o (ctrl_ready),
    .op_i       (operation_i),
    .nofit_i    (nofit),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .l_o        (l_idx),
    .k_o        (k_idx),
    .st_we_o    (st_we),
    .res_nofit_o(res_nofit),
    .out_load_o (out_load)
  );

  lsi_datapath #(
    .StencilHalf   (STENCIL_HALF),
    .MaxLevels     (MAX_LEVELS),
    .PointsPerLevel(POINTS_PER_LEVEL)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .l_i        (l_idx),
    .k_i        (k_idx),
    .st_we_i    (st_we),
    .st_level_i (level_i),
    .st_index_i (point_index_i),
    .st_pos_i   (point_position_i),
    .st_coef_i  (point_coefficient_i),
    .ev_level_i (level_i),
    .ev_pos_i   (eval_position_i),
    .ev_center_i(center_index_i),
    .ev_count_i (points_at_level_i),
    .nofit_o    (nofit),
    .value_o    (dp_value),
    .status_o   (dp_status)
  );

  // Output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      value_q  <= res_nofit ? '0 : dp_value;
      status_q <= res_nofit ? lsi_pkg::StatusNoFit : dp_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

endmodule

/* tb/lagrange_stencil_interpolator_tb.sv */
// Self-checking testbench for the Lagrange stencil interpolator.
`timescale 1ns / 100ps

module lagrange_stencil_interpolator_tb;

  localparam int unsigned HalfSpan = 2;
  localparam int unsigned Span = 2 * HalfSpan;
  localparam int unsigned Levels = 8;
  localparam int unsigned PerLevel = 256;
  localparam longint One = 65536;
  localparam longint CycleLimit = 20_000_000;

  typedef struct {
    logic              op;
    logic [2:0]        level;
    logic [7:0]        pidx;
    logic signed [31:0] ppos;
    logic signed [31:0] pcoef;
    logic signed [31:0] xpos;
    logic [7:0]        center;
    logic [8:0]        npts;
    bit                drain;
  } lsi_word_t;

  typedef struct {
    logic signed [31:0] value;
    logic [1:0]         status;
  } lsi_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready_o;
  logic operation = lsi_pkg::OpStore;
  logic [2:0] level = '0;
  logic [7:0] point_index = '0;
  logic signed [31:0] point_position = '0;
  logic signed [31:0] point_coefficient = '0;
  logic signed [31:0] eval_position = '0;
  logic [7:0] center_index = '0;
  logic [8:0] points_at_level = '0;
  logic out_valid_o;
  logic out_ready = 1'b0;
  logic signed [31:0] value_o;
  logic [1:0] status_o;

  lagrange_stencil_interpolator DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready_o),
    .operation_i(operation), .level_i(level), .point_index_i(point_index),
    .point_position_i(point_position), .point_coefficient_i(point_coefficient),
    .eval_position_i(eval_position), .center_index_i(center_index),
    .points_at_level_i(points_at_level),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready),
    .value_o(value_o), .status_o(status_o)
  );

  lsi_word_t   pending_words[$];
  lsi_result_t expected_results[$];

  // Shadow of the point store, kept by the predictor
  logic signed [31:0] shadow_pos[Levels*PerLevel];
  logic signed [31:0] shadow_coef[Levels*PerLevel];

  // Generator bookkeeping: points written in order per level
  int unsigned filled[Levels];

  longint cycles = 0;
  int errors = 0;
  int n_stores = 0, n_evals = 0, n_results = 0;
  int status_seen[4];
  bit word_taken = 1'b0;
  bit quiet_phase = 1'b0;
  int in_gap = 0, out_gap = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Rounded division, halves away from zero
  function automatic longint div_half_away(longint n, longint d);
    bit neg;
    longint unsigned an, ad, q;
    neg = (n < 0) != (d < 0);
    an = (n < 0) ? -n : n;
    ad = (d < 0) ? -d : d;
    q = (2 * an + ad) / (2 * ad);
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clip_weight(longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483647) begin
      sat = 1'b1;
      return -64'sd2147483647;
    end
    return v;
  endfunction

  // Work out the interpolated value and status for one evaluate word
  function automatic lsi_result_t interpolate(lsi_word_t w);
    lsi_result_t res;
    longint left, base, x, sum, wt, r;
    longint pos[Span];
    longint coef[Span];
    bit sat;
    res.value = '0;
    res.status = lsi_pkg::StatusNoFit;
    if (w.level >= Levels || w.npts < Span || w.npts > PerLevel) return res;
    left = longint'(w.center) - HalfSpan + 1;
    if (left < 0) left = 0;
    if (left > longint'(w.npts) - Span) left = longint'(w.npts) - Span;
    base = longint'(w.level) * PerLevel;
    for (int l = 0; l < Span; l++) begin
      pos[l] = shadow_pos[base + left + l];
      coef[l] = shadow_coef[base + left + l];
    end
    for (int l = 0; l < Span; l++)
      for (int k = l + 1; k < Span; k++)
        if (pos[l] == pos[k]) begin
          res.status = lsi_pkg::StatusEqualPos;
          return res;
        end
    x = w.xpos;
    sum = 0;
    sat = 1'b0;
    for (int l = 0; l < Span; l++) begin
      wt = One;
      for (int k = 0; k < Span; k++) begin
        if (k != l) begin
          r = clip_weight(div_half_away((x - pos[k]) * One, pos[l] - pos[k]), sat);
          wt = clip_weight(div_half_away(wt * r, One), sat);
        end
      end
      sum += div_half_away(wt * coef[l], One);
    end
    if (sum > 64'sd2147483647) begin
      sum = 64'sd2147483647;
      sat = 1'b1;
    end
    if (sum < -64'sd2147483648) begin
      sum = -64'sd2147483648;
      sat = 1'b1;
    end
    res.value = sum[31:0];
    res.status = sat ? lsi_pkg::StatusSat : lsi_pkg::StatusOk;
    return res;
  endfunction

  // Mostly short gaps, a few long ones, none during quiet phases
  function automatic int pick_gap();
    if (quiet_phase) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  function automatic lsi_word_t store_word(int lv, int idx, int p, int c);
    lsi_word_t w;
    w = '{op: lsi_pkg::OpStore, level: 3'(lv), pidx: 8'(idx), ppos: p, pcoef: c,
          xpos: $urandom(), center: 8'($urandom()), npts: 9'($urandom()), drain: 1'b0};
    return w;
  endfunction

  function automatic lsi_word_t eval_word(int lv, int ctr, int n, int x);
    lsi_word_t w;
    w = '{op: lsi_pkg::OpEval, level: 3'(lv), pidx: 8'($urandom()), ppos: $urandom(),
          pcoef: $urandom(), xpos: x, center: 8'(ctr), npts: 9'(n), drain: 1'b0};
    return w;
  endfunction

  // Append a store of a given point on a level, with random content
  task automatic add_random_store(int lv, int idx);
    int p, c;
    if ($urandom_range(0, 9) == 0) p = $urandom();
    else p = (idx << 16) + int'($urandom_range(0, 40000)) - 20000;
    if ($urandom_range(0, 5) == 0) c = $urandom();
    else c = int'($urandom_range(0, 1 << 20)) - (1 << 19);
    pending_words.push_back(store_word(lv, idx, p, c));
    if (idx >= filled[lv]) filled[lv] = idx + 1;
  endtask

  task automatic add_random_eval();
    int lv, n, ctr, x;
    do lv = $urandom_range(0, Levels - 1); while (filled[lv] < Span);
    ctr = $urandom_range(0, 255);
    if ($urandom_range(0, 7) == 0) begin
      n = ($urandom_range(0, 1) == 0) ? $urandom_range(0, Span - 1)
                                      : $urandom_range(PerLevel + 1, 511);
    end else begin
      n = $urandom_range(Span, filled[lv]);
    end
    if ($urandom_range(0, 6) == 0) x = $urandom();
    else x = (ctr << 16) + int'($urandom_range(0, 1 << 18)) - (1 << 17);
    pending_words.push_back(eval_word(lv, ctr, n, x));
  endtask

  // Fill the word queue: directed cases first, then random traffic
  initial begin
    lsi_word_t w;
    for (int i = 0; i < Levels * PerLevel; i++) begin
      shadow_pos[i] = '0;
      shadow_coef[i] = '0;
    end
    for (int i = 0; i < Levels; i++) filled[i] = 0;
    for (int i = 0; i < 4; i++) status_seen[i] = 0;

    // Level 0: evenly spaced points, extreme coefficients
    pending_words.push_back(store_word(0, 0, 0, 32'sh7fffffff));
    pending_words.push_back(store_word(0, 1, 1 << 16, 32'sh80000000));
    pending_words.push_back(store_word(0, 2, 2 << 16, 3 << 16));
    pending_words.push_back(store_word(0, 3, 3 << 16, -(1 << 16)));
    pending_words.push_back(store_word(0, 4, 4 << 16, 5 << 15));
    pending_words.push_back(store_word(0, 5, 5 << 16, 0));
    filled[0] = 6;
    // Level 1: two points share a position
    pending_words.push_back(store_word(1, 0, 7 << 16, 1 << 16));
    pending_words.push_back(store_word(1, 1, 8 << 16, 1 << 16));
    pending_words.push_back(store_word(1, 2, 7 << 16, 1 << 16));
    pending_words.push_back(store_word(1, 3, 9 << 16, 1 << 16));
    filled[1] = 4;
    // Level 2: extreme positions
    pending_words.push_back(store_word(2, 0, 32'sh80000000, 1 << 16));
    pending_words.push_back(store_word(2, 1, -1, -(1 << 16)));
    pending_words.push_back(store_word(2, 2, 0, 1 << 16));
    pending_words.push_back(store_word(2, 3, 32'sh7fffffff, 2 << 16));
    filled[2] = 4;

    pending_words.push_back(eval_word(0, 0, 6, 1 << 15));          // stencil clamped low
    pending_words.push_back(eval_word(0, 255, 6, 9 << 15));        // centre beyond level
    pending_words.push_back(eval_word(0, 2, 6, 2 << 16));          // exactly on a point
    pending_words.push_back(eval_word(0, 2, 3, 0));                // too few points
    pending_words.push_back(eval_word(0, 2, 0, 0));
    pending_words.push_back(eval_word(0, 2, 511, 0));              // count above level size
    pending_words.push_back(eval_word(0, 2, 257, 0));
    pending_words.push_back(eval_word(1, 1, 4, 8 << 16));          // equal positions
    pending_words.push_back(eval_word(0, 2, 6, 32'sh7fffffff));    // far out: saturates
    pending_words.push_back(eval_word(0, 2, 6, 32'sh80000000));
    pending_words.push_back(eval_word(2, 1, 4, 12345));            // extreme positions
    w = eval_word(2, 1, 4, -1);
    w.drain = 1'b1;
    pending_words.push_back(w);

    // Level 7 filled completely so a full-size level can be evaluated
    for (int i = 0; i < PerLevel; i++) add_random_store(7, i);
    w = eval_word(7, 255, PerLevel, 254 << 16);
    w.drain = 1'b1;
    pending_words.push_back(w);

    // Mixed traffic: grow levels in order, overwrite, evaluate
    while (pending_words.size() < 1050) begin
      int lv;
      if ($urandom_range(0, 99) < 60) begin
        lv = $urandom_range(0, Levels - 1);
        if (filled[lv] < PerLevel && $urandom_range(0, 2) != 0) add_random_store(lv, filled[lv]);
        else if (filled[lv] > 0) add_random_store(lv, $urandom_range(0, filled[lv] - 1));
        else add_random_store(lv, 0);
      end else begin
        add_random_eval();
      end
      if ($urandom_range(0, 199) == 0) pending_words[$].drain = 1'b1;
    end
  end

  // Reset, then wait for all words to drain and finish
  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i);
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (200) @(posedge clk_i);
    $display("Covered %0d point stores and %0d evaluations, %0d results checked.",
             n_stores, n_evals, n_results);
    $display("Status mix: ok %0d, no fit %0d, equal positions %0d, saturated %0d.",
             status_seen[lsi_pkg::StatusOk], status_seen[lsi_pkg::StatusNoFit],
             status_seen[lsi_pkg::StatusEqualPos], status_seen[lsi_pkg::StatusSat]);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Drive input words and output back-pressure on the falling edge
  always @(negedge clk_i) begin
    lsi_word_t w;
    if (rst_ni) begin
      if ($urandom_range(0, 49) == 0) quiet_phase = ~quiet_phase;
      if (!in_valid || word_taken) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap--;
        end else if (pending_words.size() != 0 &&
                     !(pending_words[0].drain && expected_results.size() != 0)) begin
          w = pending_words.pop_front();
          operation <= w.op;
          level <= w.level;
          point_index <= w.pidx;
          point_position <= w.ppos;
          point_coefficient <= w.pcoef;
          eval_position <= w.xpos;
          center_index <= w.center;
          points_at_level <= w.npts;
          in_valid <= 1'b1;
          in_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
      // Stall the result side at random
      if (out_gap > 0) begin
        out_ready <= 1'b0;
        out_gap--;
      end else begin
        out_ready <= 1'b1;
        out_gap = pick_gap();
      end
    end
  end

  // Sample handshakes on the rising edge: predict accepted words, check results
  always @(posedge clk_i) begin
    lsi_word_t w;
    lsi_result_t want;
    int idx;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
    word_taken = rst_ni && in_valid && in_ready_o;
    if (word_taken) begin
      w = '{op: operation, level: level, pidx: point_index, ppos: point_position,
            pcoef: point_coefficient, xpos: eval_position, center: center_index,
            npts: points_at_level, drain: 1'b0};
      if (w.op == lsi_pkg::OpStore) begin
        n_stores++;
        idx = int'(w.level) * PerLevel + int'(w.pidx);
        shadow_pos[idx] = w.ppos;
        shadow_coef[idx] = w.pcoef;
      end else begin
        n_evals++;
        expected_results.push_back(interpolate(w));
      end
    end
    if (rst_ni && out_valid_o && out_ready) begin
      n_results++;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result word: value %h status %0d",
                                   value_o, status_o);
      end else begin
        want = expected_results.pop_front();
        status_seen[want.status]++;
        if (value_o !== want.value || status_o !== want.status) begin
          errors++;
          if (errors <= 10)
            $display("Mismatch at cycle %0d: value %h/%h status %0d/%0d (expected/actual)",
                     cycles, want.value, value_o, want.status, status_o);
        end
      end
    end
  end

endmodule

/* files.f */
hdl/lsi_pkg.sv
hdl/lsi_divider.sv
hdl/lsi_datapath.sv
hdl/lsi_ctrl.sv
hdl/lagrange_stencil_interpolator.sv
tb/lagrange_stencil_interpolator_tb.sv
